// ===== rtl/q15mm_pkg.sv =====
// ----------------------------------------------------------------------------
// q15mm_pkg: shared types and constants of the Q15 matrix multiplier
// Payload structs, action codes, register indexes, sizes and the
// control bundles that pass between the sequencer, the MAC unit and the top.
// ----------------------------------------------------------------------------
package q15mm_pkg;

  // Largest matrix side that the stores hold.
  localparam int MAX_DIM = 8;
  // Largest side that a run can use; the index fields are three bits wide.
  localparam int DIM_LIM = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int IDX_W   = (DIM_LIM > 1) ? $clog2(DIM_LIM) : 1;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int DATA_W = 16;
  localparam int DIM_W  = 4;

  localparam logic signed [16:0] Q15_MAX   = 17'sh07FFF;
  localparam logic signed [16:0] Q15_MIN   = -17'sh08000;
  localparam logic signed [31:0] Q15_ROUND = 32'sd1 <<< (15 - 1);
  localparam int                 Q15_SHIFT = 15;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [1:0] CFG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOLD,
    ST_ISSUE,
    ST_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [2:0]               row;
    logic [2:0]               col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product_value;
    logic [2:0]               out_row;
    logic [2:0]               out_col;
    logic                     element_saturated;
    logic                     any_saturated;
    logic                     last;
  } out_item_t;

  // One step of the inner product as issued by the sequencer.
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              lastk;
    logic              zero;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
  } seq_issue_t;

  // Position of the element currently being worked on.
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
  } seq_elem_t;

  // Step control as seen by the MAC unit, aligned with the operands.
  typedef struct packed {
    logic valid;
    logic first;
    logic lastk;
  } mac_ctl_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } mac_res_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    return (r < DIM_W'(DIM_LIM)) ? r : DIM_W'(DIM_LIM);
  endfunction

endpackage

// ===== rtl/q15_saturating_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// q15_saturating_matrix_multiply: Q15 matrix product with saturation
// Loads matrices A and B element by element, then streams A*B row-major.
// ----------------------------------------------------------------------------
// Throughput: loads transfer one per cycle while no compute run is busy. A
// compute transfer holds the input for the whole run; each result element
// passes through the shared multiply-accumulate unit, and an output stall
// holds back the start of the next element.
// Reset: the size registers return to 8 and both stores read as all zero at
// once through per-entry valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module q15_saturating_matrix_multiply
  import q15mm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // Input item channel.
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  // Result item channel.
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  // Configuration write port.
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_wdata
);

  // Size registers; user must write only while the block is idle (unenforced).
  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0] nr, nk, nc;

  // Per-entry valid bits: an entry never loaded since reset reads as zero.
  logic [DEPTH-1:0] a_vld_r, b_vld_r;

  logic              in_xfer;
  logic              load_ok;
  logic              we_a, we_b;
  logic [ADDR_W-1:0] waddr;
  logic              start;

  logic              seq_busy;
  seq_issue_t        issue;
  seq_elem_t         elem;

  logic [DATA_W-1:0] a_rdata, b_rdata;
  logic              a_ok_r, b_ok_r;
  mac_ctl_t          ctl_r;
  logic signed [DATA_W-1:0] a_op, b_op;
  mac_res_t          res;

  logic              any_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  // The input is held off for the whole of a compute run.
  assign in_stall = seq_busy;
  assign in_xfer  = in_valid && !in_stall;

  // Loads outside the store are dropped; the unused action code does nothing.
  assign load_ok = (5'(in_data.row) < 5'(MAX_DIM)) && (5'(in_data.col) < 5'(MAX_DIM));
  assign we_a    = in_xfer && (in_data.action == ACT_LOAD_A) && load_ok;
  assign we_b    = in_xfer && (in_data.action == ACT_LOAD_B) && load_ok;
  assign waddr   = ADDR_W'(in_data.row * MAX_DIM + in_data.col);

  // Effective sizes; a run with no rows or no columns emits nothing.
  assign nr    = eff_dim(rows_a_r);
  assign nk    = eff_dim(inner_dim_r);
  assign nc    = eff_dim(cols_b_r);
  assign start = in_xfer && (in_data.action == ACT_COMPUTE) && (nr != '0) && (nc != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(8);
      inner_dim_r <= DIM_W'(8);
      cols_b_r    <= DIM_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_A:    rows_a_r    <= cfg_wdata;
        CFG_INNER_DIM: inner_dim_r <= cfg_wdata;
        CFG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
      b_vld_r <= '0;
    end else begin
      if (we_a) begin
        a_vld_r[waddr] <= 1'b1;
      end
      if (we_b) begin
        b_vld_r[waddr] <= 1'b1;
      end
    end
  end

  q15mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(ADDR_W)) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_data.value),
    .raddr (issue.a_addr),
    .rdata (a_rdata)
  );

  q15mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(ADDR_W)) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_data.value),
    .raddr (issue.b_addr),
    .rdata (b_rdata)
  );

  q15mm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .nr        (nr),
    .nk        (nk),
    .nc        (nc),
    .out_busy  (out_valid_r),
    .res_valid (res.valid),
    .busy      (seq_busy),
    .issue     (issue),
    .elem      (elem)
  );

  // Step control and valid-bit lookups are registered with the RAM read, so
  // they line up with its data. With a zero inner dimension the single issued
  // step is forced to zero operands, giving a zero result without saturation.
  always_ff @(posedge clk) begin
    a_ok_r <= a_vld_r[issue.a_addr] && !issue.zero;
    b_ok_r <= b_vld_r[issue.b_addr] && !issue.zero;
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid <= issue.valid;
      ctl_r.first <= issue.first;
      ctl_r.lastk <= issue.lastk;
    end
  end

  assign a_op = a_ok_r ? $signed(a_rdata) : '0;
  assign b_op = b_ok_r ? $signed(b_rdata) : '0;

  q15mm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_r),
    .a     (a_op),
    .b     (b_op),
    .res   (res)
  );

  // Output register. The sequencer starts an element only when this register
  // is empty, so a finished element always finds room here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      if (start) begin
        any_r <= 1'b0;
      end else if (res.valid) begin
        any_r <= any_r | res.sat;
      end
      if (res.valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res.valid) begin
      out_data_r.product_value     <= res.value;
      out_data_r.out_row           <= elem.row;
      out_data_r.out_col           <= elem.col;
      out_data_r.element_saturated <= res.sat;
      out_data_r.any_saturated     <= any_r | res.sat;
      out_data_r.last              <= elem.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/q15mm_ram.sv =====
// ----------------------------------------------------------------------------
// q15mm_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module q15mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/q15mm_mac.sv =====
// ----------------------------------------------------------------------------
// q15mm_mac: shared Q15 multiply-accumulate unit
// Registered product, then rounding, saturation and a saturating accumulate.
// ----------------------------------------------------------------------------
module q15mm_mac
  import q15mm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output mac_res_t                 res
);

  logic signed [31:0]       prod_r;
  mac_ctl_t                 ctl_r;
  logic signed [DATA_W-1:0] acc_r, acc_nxt;
  logic                     esat_r, esat_nxt;
  logic                     res_valid_r;

  logic signed [31:0]       rounded;
  logic signed [16:0]       scaled;
  logic signed [DATA_W-1:0] p16;
  logic                     p_sat;
  logic signed [DATA_W-1:0] base;
  logic signed [16:0]       sum;
  logic                     s_sat;

  always_comb begin
    rounded = prod_r + Q15_ROUND;
    scaled  = rounded[Q15_SHIFT+16:Q15_SHIFT];
    p_sat   = (scaled > Q15_MAX) || (scaled < Q15_MIN);
    if (scaled > Q15_MAX) begin
      p16 = Q15_MAX[DATA_W-1:0];
    end else if (scaled < Q15_MIN) begin
      p16 = Q15_MIN[DATA_W-1:0];
    end else begin
      p16 = scaled[DATA_W-1:0];
    end
    base  = ctl_r.first ? '0 : acc_r;
    sum   = 17'(base) + 17'(p16);
    s_sat = (sum > Q15_MAX) || (sum < Q15_MIN);
    if (sum > Q15_MAX) begin
      acc_nxt = Q15_MAX[DATA_W-1:0];
    end else if (sum < Q15_MIN) begin
      acc_nxt = Q15_MIN[DATA_W-1:0];
    end else begin
      acc_nxt = sum[DATA_W-1:0];
    end
    esat_nxt = (ctl_r.first ? 1'b0 : esat_r) | p_sat | s_sat;
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (ctl_r.valid) begin
      acc_r  <= acc_nxt;
      esat_r <= esat_nxt;
    end
    if (!rst_n) begin
      ctl_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl;
      res_valid_r <= ctl_r.valid & ctl_r.lastk;
    end
  end

  assign res.valid = res_valid_r;
  assign res.value = acc_r;
  assign res.sat   = esat_r;

endmodule

// ===== rtl/q15mm_seq.sv =====
// ----------------------------------------------------------------------------
// q15mm_seq: run sequencer of the matrix multiplier
// Walks rows, columns and inner index; issues one step per cycle in ST_ISSUE.
// ----------------------------------------------------------------------------
module q15mm_seq
  import q15mm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIM_W-1:0] nr,
  input  logic [DIM_W-1:0] nk,
  input  logic [DIM_W-1:0] nc,
  input  logic             out_busy,
  input  logic             res_valid,
  output logic             busy,
  output seq_issue_t       issue,
  output seq_elem_t        elem
);

  seq_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] r_r, r_nxt;
  logic [IDX_W-1:0] c_r, c_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;

  logic zero_k;
  logic lastk;
  logic row_end;
  logic col_end;

  always_comb begin
    zero_k  = (nk == '0);
    lastk   = zero_k || (DIM_W'(k_r) == nk - DIM_W'(1));
    row_end = (DIM_W'(r_r) == nr - DIM_W'(1));
    col_end = (DIM_W'(c_r) == nc - DIM_W'(1));

    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;

    issue.valid  = 1'b0;
    issue.first  = (k_r == '0);
    issue.lastk  = lastk;
    issue.zero   = zero_k;
    issue.a_addr = ADDR_W'(r_r * MAX_DIM + k_r);
    issue.b_addr = ADDR_W'(k_r * MAX_DIM + c_r);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_busy) begin
          k_nxt     = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue.valid = 1'b1;
        if (lastk) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (res_valid) begin
          if (row_end && col_end) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
            if (col_end) begin
              c_nxt = '0;
              r_nxt = r_r + IDX_W'(1);
            end else begin
              c_nxt = c_r + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign elem.row  = 3'(r_r);
  assign elem.col  = 3'(c_r);
  assign elem.last = row_end && col_end;

endmodule

// ===== bench/q15_saturating_matrix_multiply_tb.sv =====
// ----------------------------------------------------------------------------
// q15_saturating_matrix_multiply_tb: self-checking bench of the Q15 multiplier
// A short stimulus table covers the reset state, the Q15 extremes, every action
// and the corner cases of the size registers. Randomized load and compute
// sequences with random back-pressure follow. A shadow copy of both stores
// predicts every untyped result element; each is compared field by field.
// ----------------------------------------------------------------------------
module q15_saturating_matrix_multiply_tb;
  import q15mm_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 300;
  // The last fifth of the random part runs without any idling on either side.
  localparam int CALM_FROM    = RANDOM_ITEMS * 4 / 5;
  // Wait before touching the size registers: twice the longest time that a
  // result element needs, plus some margin.
  localparam int DRAIN_CYCLES = 2 * (DIM_LIM + 5) + 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_REPORTS  = 10;
  localparam int IN_BITS      = $bits(in_item_t);

  // Action code 3 has no meaning; the block must drop it silently.
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  localparam int SAT_HI     = 32767;
  localparam int SAT_LO     = -32768;
  localparam int ROUND_HALF = 1 << (15 - 1);
  localparam int FRAC_BITS  = 15;

  // One row of the directed stimulus table.
  typedef struct packed {
    logic             is_cfg;
    logic [1:0]       cfg_idx;
    logic [DIM_W-1:0] cfg_val;
    in_item_t         item;
    logic             has_exp;
    out_item_t        exp;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [DIM_W-1:0] cfg_wdata = '0;

  // Shadow state: both stores and the three size registers.
  logic signed [DATA_W-1:0] a_shadow [DIM_LIM][DIM_LIM];
  logic signed [DATA_W-1:0] b_shadow [DIM_LIM][DIM_LIM];
  logic [DIM_W-1:0]         rows_sh = 4'd8;
  logic [DIM_W-1:0]         inner_sh = 4'd8;
  logic [DIM_W-1:0]         cols_sh = 4'd8;

  out_item_t   pending_results [$];
  plan_row_t   plan [$];
  int          fail_count = 0;
  int          random_count = 0;
  logic        in_random_part = 1'b0;
  logic        idle_on = 1'b1;
  int          mode_timer = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;
  logic        quiet_tail;

  assign quiet_tail = (random_count >= CALM_FROM);

  q15_saturating_matrix_multiply u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // A size register above the store side is clamped to it.
  function automatic int used_dim(input logic [DIM_W-1:0] v);
    return (int'(v) > DIM_LIM) ? DIM_LIM : int'(v);
  endfunction

  // Applies one accepted item to the shadow stores. A compute item walks the
  // product in row-major order and queues one expected element per position.
  // Each Q15 product is rounded, floored by the arithmetic shift and clamped,
  // and every partial sum is clamped again.
  function automatic void mirror_item(input in_item_t item);
    int        nr;
    int        nk;
    int        nc;
    int        acc;
    int        prod;
    logic      esat;
    logic      anys;
    out_item_t res;
    case (item.action)
      ACT_LOAD_A: a_shadow[item.row][item.col] = item.value;
      ACT_LOAD_B: b_shadow[item.row][item.col] = item.value;
      ACT_COMPUTE: begin
        nr = used_dim(rows_sh);
        nk = used_dim(inner_sh);
        nc = used_dim(cols_sh);
        anys = 1'b0;
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) begin
            acc = 0;
            esat = 1'b0;
            for (int k = 0; k < nk; k++) begin
              prod = int'(a_shadow[r][k]) * int'(b_shadow[k][c]) + ROUND_HALF;
              prod = prod >>> FRAC_BITS;
              if (prod > SAT_HI) begin
                prod = SAT_HI;
                esat = 1'b1;
              end else if (prod < SAT_LO) begin
                prod = SAT_LO;
                esat = 1'b1;
              end
              acc = acc + prod;
              if (acc > SAT_HI) begin
                acc = SAT_HI;
                esat = 1'b1;
              end else if (acc < SAT_LO) begin
                acc = SAT_LO;
                esat = 1'b1;
              end
            end
            anys = anys | esat;
            res.product_value     = acc[DATA_W-1:0];
            res.out_row           = r[2:0];
            res.out_col           = c[2:0];
            res.element_saturated = esat;
            res.any_saturated     = anys;
            res.last              = (r == nr - 1) && (c == nc - 1);
            pending_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Compares one accepted result element with the oldest expectation.
  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("unexpected result: value %0d row %0d col %0d sat %b any %b last %b",
                 got.product_value, got.out_row, got.out_col,
                 got.element_saturated, got.any_saturated, got.last);
      return;
    end
    want = pending_results.pop_front();
    if (got.product_value !== want.product_value || got.out_row !== want.out_row ||
        got.out_col !== want.out_col ||
        got.element_saturated !== want.element_saturated ||
        got.any_saturated !== want.any_saturated || got.last !== want.last) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("mismatch: expected value %0d row %0d col %0d sat %b any %b last %b",
                 want.product_value, want.out_row, want.out_col,
                 want.element_saturated, want.any_saturated, want.last);
        $display("          actual   value %0d row %0d col %0d sat %b any %b last %b",
                 got.product_value, got.out_row, got.out_col,
                 got.element_saturated, got.any_saturated, got.last);
      end
    end
  endfunction

  // Results are sampled on the rising edge, where stall is stable.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // Result side back-pressure comes in random stall bursts, and idling is
  // switched on or off by a mode timer so that quiet stretches occur.
  always @(negedge clk) begin
    if (mode_timer == 0) begin
      mode_timer = 150;
      idle_on = ($urandom_range(0, 3) != 0);
    end else begin
      mode_timer--;
    end
    if (!rst_n || quiet_tail) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_stall = 1'b0;
    end
  end

  // Drives one item and holds it until the transfer happens. The expectation
  // is either the typed-in one from the table or the shadow prediction.
  // Valid stays high afterwards; the next call or a pause decides its fate.
  task automatic transfer_item(input in_item_t item, input logic typed,
                               input out_item_t typed_res);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (in_stall);
    if (typed) pending_results.push_back(typed_res);
    else mirror_item(item);
    if (in_random_part && item.action != ACT_IGNORED) random_count++;
    // Sender idling: a random burst with valid low and junk on the bus.
    if (!quiet_tail && idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid = 1'b0;
      in_data = in_item_t'(IN_BITS'($urandom));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stops sending and waits for every expected element, then lets the MAC
  // pipeline empty.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      CFG_ROWS_A:    rows_sh = val;
      CFG_INNER_DIM: inner_sh = val;
      CFG_COLS_B:    cols_sh = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic void plan_cfg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.cfg_idx = idx;
    p.cfg_val = val;
    plan.push_back(p);
  endfunction

  function automatic void plan_item(input logic [1:0] act, input logic [2:0] row,
                                    input logic [2:0] col, input logic [15:0] val);
    plan_row_t p;
    p = '0;
    p.item.action = act;
    p.item.row = row;
    p.item.col = col;
    p.item.value = val;
    plan.push_back(p);
  endfunction

  // A compute on 1x1x1 sizes whose only element is obvious from the operands.
  function automatic void plan_single_result(input logic [15:0] val, input logic esat,
                                             input logic anys);
    plan_row_t p;
    p = '0;
    p.item.action = ACT_COMPUTE;
    p.has_exp = 1'b1;
    p.exp.product_value = val;
    p.exp.element_saturated = esat;
    p.exp.any_saturated = anys;
    p.exp.last = 1'b1;
    plan.push_back(p);
  endfunction

  // Size picks: mostly small matrices, some full size, some out of range
  // (clamped to the store side) and a few zero sizes.
  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return DIM_W'($urandom_range(1, 4));
    if (r < 80) return DIM_W'(8);
    if (r < 88) return DIM_W'($urandom_range(9, 15));
    if (r < 93) return '0;
    return DIM_W'($urandom_range(1, 8));
  endfunction

  // Element values: Q15 extremes, full random words, large magnitudes that
  // push the sums into saturation, and small values that stay linear.
  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        case ($urandom_range(0, 4))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = 16'hFFFF;
          3:       v = 16'h0001;
          default: v = 16'h0000;
        endcase
      end
      3, 4, 5: v = 16'($urandom);
      6, 7: begin
        v = 16'($urandom_range(16'h6000, 16'h7FFF));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        v = 16'($urandom_range(0, 16'h03FF));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // Sends one load, occasionally preceded by noise: an ignored action or a
  // load to an arbitrary position, which later shows up as a stale element.
  task automatic send_load(input logic [1:0] act, input int row, input int col);
    in_item_t it;
    out_item_t none;
    none = '0;
    if ($urandom_range(0, 11) == 0) begin
      it = in_item_t'(IN_BITS'($urandom));
      if ($urandom_range(0, 1) == 0) it.action = ACT_IGNORED;
      else it.action = ($urandom_range(0, 1) == 0) ? ACT_LOAD_A : ACT_LOAD_B;
      transfer_item(it, 1'b0, none);
    end
    it.action = act;
    it.row = row[2:0];
    it.col = col[2:0];
    it.value = pick_value();
    transfer_item(it, 1'b0, none);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    in_item_t   it;
    out_item_t  none;
    logic [DIM_W-1:0] d_rows;
    logic [DIM_W-1:0] d_inner;
    logic [DIM_W-1:0] d_cols;
    int         nr;
    int         nk;
    int         nc;
    int         phase;

    none = '0;
    for (int r = 0; r < DIM_LIM; r++) begin
      for (int c = 0; c < DIM_LIM; c++) begin
        a_shadow[r][c] = '0;
        b_shadow[r][c] = '0;
      end
    end

    // Directed table. On 1x1x1 sizes the single element is typed in where it
    // is plain: cleared stores give zero, the largest positive square rounds
    // down to 32766, and the square of the most negative value clips.
    plan_cfg(CFG_ROWS_A, 4'd1);
    plan_cfg(CFG_INNER_DIM, 4'd1);
    plan_cfg(CFG_COLS_B, 4'd1);
    plan_single_result(16'sd0, 1'b0, 1'b0);
    plan_item(ACT_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
    plan_item(ACT_LOAD_B, 3'd0, 3'd0, 16'h7FFF);
    plan_single_result(16'sd32766, 1'b0, 1'b0);
    plan_item(ACT_LOAD_A, 3'd0, 3'd0, 16'h8000);
    plan_item(ACT_LOAD_B, 3'd0, 3'd0, 16'h8000);
    plan_single_result(16'sd32767, 1'b1, 1'b1);
    plan_item(ACT_LOAD_B, 3'd0, 3'd0, 16'h7FFF);
    plan_item(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);
    // The unused action must neither write a store nor produce output.
    plan_item(ACT_IGNORED, 3'd7, 3'd7, 16'hFFFF);
    // Zero inner size: the element is zero and never saturates.
    plan_cfg(CFG_INNER_DIM, 4'd0);
    plan_single_result(16'sd0, 1'b0, 1'b0);
    // Zero rows: a compute produces nothing at all.
    plan_cfg(CFG_ROWS_A, 4'd0);
    plan_item(ACT_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
    plan_item(ACT_LOAD_A, 3'd7, 3'd7, 16'h5555);
    plan_item(ACT_LOAD_B, 3'd7, 3'd7, 16'hAAAA);
    // Out-of-range sizes clamp to full size and read every stale element.
    plan_cfg(CFG_ROWS_A, 4'd15);
    plan_cfg(CFG_INNER_DIM, 4'd9);
    plan_cfg(CFG_COLS_B, 4'd8);
    plan_item(ACT_COMPUTE, 3'd5, 3'd2, 16'h1234);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) wait_idle();
        write_register(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        transfer_item(plan[i].item, plan[i].has_exp, plan[i].exp);
      end
    end

    // Random part: each phase picks new sizes, loads mostly complete matrices
    // in row-major order with some elements skipped, then computes.
    in_random_part = 1'b1;
    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      wait_idle();
      d_rows = pick_dim();
      d_inner = pick_dim();
      d_cols = pick_dim();
      write_register(CFG_ROWS_A, d_rows);
      write_register(CFG_INNER_DIM, d_inner);
      write_register(CFG_COLS_B, d_cols);
      nr = used_dim(d_rows);
      nk = used_dim(d_inner);
      nc = used_dim(d_cols);
      for (int r = 0; r < nr; r++)
        for (int k = 0; k < nk; k++)
          if ($urandom_range(0, 9) != 0) send_load(ACT_LOAD_A, r, k);
      for (int k = 0; k < nk; k++)
        for (int c = 0; c < nc; c++)
          if ($urandom_range(0, 9) != 0) send_load(ACT_LOAD_B, k, c);
      it = in_item_t'(IN_BITS'($urandom));
      it.action = ACT_COMPUTE;
      transfer_item(it, 1'b0, none);
      // A repeated compute must restart the running saturation flag. Before
      // it, the sender holds off until the previous product has fully left.
      if (phase == 0 || $urandom_range(0, 3) == 0) begin
        wait_idle();
        it = in_item_t'(IN_BITS'($urandom));
        it.action = ACT_COMPUTE;
        transfer_item(it, 1'b0, none);
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
